// ===== design/gst_pkg.sv =====
// Package for the gated stimulation trigger.
// Holds sizes, opcodes, register indexes and the field helpers.
// No dependencies.
package gst_pkg;

  localparam int NUM_REGIONS = 4;
  localparam int PULSE_MS    = 10;
  localparam int PACKED_REGIONS = 4;
  localparam int MASK_W      = 4;
  localparam int ELAPSED_W   = (NUM_REGIONS < PACKED_REGIONS) ? NUM_REGIONS : PACKED_REGIONS;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam logic [6:0] FULL_PERCENT = 7'd100;

  typedef enum logic {
    OP_TICK    = 1'b0,
    OP_REQUEST = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALLOW_MASK      = 3'd0,
    CFG_INTERVAL_MASK   = 3'd1,
    CFG_TIMEOUT_ENABLE  = 3'd2,
    CFG_REGION_PERIODS  = 3'd3,
    CFG_REGION_PERCENTS = 3'd4
  } cfg_idx_t;

  typedef logic [15:0] ms16_t;

  function automatic ms16_t period_of(input logic [63:0] periods, input int r);
    if (r >= PACKED_REGIONS) begin
      return '0;
    end
    return periods[16*r +: 16];
  endfunction

  function automatic logic [6:0] percent_of(input logic [27:0] pcts, input int r);
    logic [6:0] p;
    if (r >= PACKED_REGIONS) begin
      return '0;
    end
    p = pcts[7*r +: 7];
    return (p > FULL_PERCENT) ? FULL_PERCENT : p;
  endfunction

  function automatic ms16_t sat_sub(input ms16_t a, input ms16_t b);
    return (b >= a) ? '0 : ms16_t'(a - b);
  endfunction

endpackage

// ===== design/gst_if.sv =====
// Channel interfaces of the gated stimulation trigger: input, result, config write.
// Depends on gst_pkg.
interface gst_in_if;
  logic               valid;
  logic               ready;
  gst_pkg::op_t       op;
  logic [1:0]         region;
  logic [15:0]        delta_ms;
  logic [31:0]        now_ms;
  logic [6:0]         random_draw;

  modport source (output valid, op, region, delta_ms, now_ms, random_draw, input ready);
  modport sink   (input valid, op, region, delta_ms, now_ms, random_draw, output ready);
endinterface

interface gst_out_if;
  logic                       valid;
  logic                       ready;
  logic                       stimulated;
  logic                       draw_rejected;
  logic                       pulse_restart;
  logic                       pin_level;
  logic [gst_pkg::MASK_W-1:0] elapsed_mask;

  modport source (output valid, stimulated, draw_rejected, pulse_restart,
                  pin_level, elapsed_mask, input ready);
  modport sink   (input valid, stimulated, draw_rejected, pulse_restart,
                  pin_level, elapsed_mask, output ready);
endinterface

interface gst_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [gst_pkg::CFG_IDX_W-1:0]  index;
  logic [gst_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/gated_stimulation_trigger.sv =====
// Gated stimulation trigger: refractory countdowns, gated requests, pulse timer.
// Depends on gst_pkg and the channel interfaces in gst_if.sv.
//
//  channel  | dir | payload
//  in_ch    | in  | op, region, delta_ms, now_ms, random_draw
//  out_ch   | out | stimulated, draw_rejected, pulse_restart, pin_level, elapsed_mask
//  cfg_ch   | in  | index, data (always ready)
//
// One item per cycle sustained while out is not stalled; after the in transfer an item
// passes the input register, then state update and result register in one pass.
// rst_n is synchronous: clears state, config to defaults, empties both stages.
// An out stall holds the result; the input stage still fills, then in_ready drops.
module gated_stimulation_trigger (
  input  logic      clk,
  input  logic      rst_n,
  gst_in_if.sink    in_ch,
  gst_out_if.source out_ch,
  gst_cfg_if.sink   cfg_ch
);
  import gst_pkg::*;

  logic [MASK_W-1:0] allow_r, interval_r;
  logic              timeout_en_r;
  logic [63:0]       periods_r;
  logic [27:0]       pcts_r;

  ms16_t       cd_r   [NUM_REGIONS];
  ms16_t       cd_nxt [NUM_REGIONS];
  logic [31:0] last_time_r, last_time_nxt;
  ms16_t       last_period_r, last_period_nxt;
  ms16_t       pulse_r, pulse_nxt;
  logic        pin_r, pin_nxt;

  logic        s1_valid_r;
  op_t         s1_op_r;
  logic [1:0]  s1_region_r;
  ms16_t       s1_delta_r;
  logic [31:0] s1_now_r;
  logic [6:0]  s1_draw_r;

  logic              out_valid_r;
  logic              stim_r, rej_r, restart_r, pin_out_r;
  logic [MASK_W-1:0] elapsed_r;
  logic              stim_nxt, rej_nxt, restart_nxt;
  logic [MASK_W-1:0] elapsed_nxt;

  logic advance;
  logic req_ok;
  ms16_t sel_period;

  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      allow_r      <= '0;
      interval_r   <= '0;
      timeout_en_r <= 1'b1;
      periods_r    <= '0;
      pcts_r       <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_ALLOW_MASK:      allow_r      <= cfg_ch.data[MASK_W-1:0];
        CFG_INTERVAL_MASK:   interval_r   <= cfg_ch.data[MASK_W-1:0];
        CFG_TIMEOUT_ENABLE:  timeout_en_r <= cfg_ch.data[0];
        CFG_REGION_PERIODS:  periods_r    <= cfg_ch.data;
        CFG_REGION_PERCENTS: pcts_r       <= cfg_ch.data[27:0];
        default: ;
      endcase
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_op_r     <= in_ch.op;
      s1_region_r <= in_ch.region;
      s1_delta_r  <= in_ch.delta_ms;
      s1_now_r    <= in_ch.now_ms;
      s1_draw_r   <= in_ch.random_draw;
    end
  end

  // state update
  always_comb begin
    cd_nxt          = cd_r;
    last_time_nxt   = last_time_r;
    last_period_nxt = last_period_r;
    pulse_nxt       = pulse_r;
    pin_nxt         = pin_r;
    stim_nxt        = 1'b0;
    rej_nxt         = 1'b0;
    restart_nxt     = 1'b0;
    sel_period      = period_of(periods_r, int'(s1_region_r));
    req_ok          = (int'(s1_region_r) < NUM_REGIONS) && allow_r[s1_region_r]
                      && (cd_r[s1_region_r] == '0);
    if (s1_op_r == OP_TICK) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        if (cd_r[r] == '0 && r < MASK_W && interval_r[r % MASK_W]) begin
          cd_nxt[r] = sat_sub(period_of(periods_r, r), s1_delta_r);
        end else begin
          cd_nxt[r] = sat_sub(cd_r[r], s1_delta_r);
        end
      end
      if (pulse_r != '0) begin
        pulse_nxt = sat_sub(pulse_r, s1_delta_r);
        if (pulse_nxt == '0) begin
          pin_nxt = 1'b0;
        end
      end
    end else if (req_ok) begin
      if (!(s1_draw_r < percent_of(pcts_r, int'(s1_region_r)))) begin
        cd_nxt[s1_region_r] = sel_period;
        rej_nxt = 1'b1;
      end else if (!(timeout_en_r
                     && ((s1_now_r - last_time_r) < {16'd0, last_period_r}))) begin
        restart_nxt         = (pulse_r != '0);
        last_time_nxt       = s1_now_r;
        last_period_nxt     = sel_period;
        pulse_nxt           = ms16_t'(PULSE_MS);
        pin_nxt             = 1'b1;
        cd_nxt[s1_region_r] = sel_period;
        stim_nxt            = 1'b1;
      end
    end
    elapsed_nxt = '0;
    for (int r = 0; r < ELAPSED_W; r++) begin
      elapsed_nxt[r] = (cd_nxt[r] == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < NUM_REGIONS; r++) begin
        cd_r[r] <= '0;
      end
      last_time_r   <= '0;
      last_period_r <= '0;
      pulse_r       <= '0;
      pin_r         <= 1'b0;
    end else if (advance) begin
      cd_r          <= cd_nxt;
      last_time_r   <= last_time_nxt;
      last_period_r <= last_period_nxt;
      pulse_r       <= pulse_nxt;
      pin_r         <= pin_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stim_r    <= stim_nxt;
      rej_r     <= rej_nxt;
      restart_r <= restart_nxt;
      pin_out_r <= pin_nxt;
      elapsed_r <= elapsed_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.stimulated    = stim_r;
  assign out_ch.draw_rejected = rej_r;
  assign out_ch.pulse_restart = restart_r;
  assign out_ch.pin_level     = pin_out_r;
  assign out_ch.elapsed_mask  = elapsed_r;

  a_pin_needs_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    pin_r |-> (pulse_r != '0))
    else $error("pin high with pulse timer at zero");

  a_stim_raises_pin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && stim_r) |-> pin_out_r)
    else $error("stimulation without pin high");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(stim_r && rej_r))
    else $error("stimulated and rejected together");

  a_restart_needs_stim: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && restart_r) |-> stim_r)
    else $error("pulse restart without stimulation");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (out_valid_r && $stable(elapsed_r)))
    else $error("stalled result lost");

endmodule
